### design/udiv128_pkg.sv
// Shared types and constants for the unsigned 128-by-64 divider.
package udiv128_pkg;

    localparam int unsigned WordWidth = 64;
    localparam int unsigned StepCount = 2 * WordWidth;
    localparam int unsigned CountWidth = $clog2(StepCount);
    localparam logic [CountWidth-1:0] LastStep = CountWidth'(StepCount - 1);

    typedef struct packed {
        logic [WordWidth-1:0] dividend_high;
        logic [WordWidth-1:0] dividend_low;
        logic [WordWidth-1:0] divisor;
    } udiv128_in_t;

    typedef struct packed {
        logic [WordWidth-1:0] quotient_high;
        logic [WordWidth-1:0] quotient_low;
        logic                 divide_by_zero;
    } udiv128_out_t;

    typedef enum logic [1:0] {
        ST_IDLE,
        ST_RUN,
        ST_DONE
    } udiv128_state_t;

    typedef struct packed {
        logic load;
        logic step;
    } udiv128_cmd_t;

    typedef struct packed {
        logic divisor_zero;
    } udiv128_status_t;

endpackage

### design/udiv128_ctrl.sv
// Sequencer for the divider: accepts a transaction, counts the steps, strobes the result.
module udiv128_ctrl (
    input  logic                        clk,
    input  logic                        rst_n,
    input  logic                        start,
    input  udiv128_pkg::udiv128_status_t status,
    output udiv128_pkg::udiv128_cmd_t    cmd,
    output logic                        busy,
    output logic                        done
);

    udiv128_pkg::udiv128_state_t state_reg, state_next;
    logic [udiv128_pkg::CountWidth-1:0] count_reg, count_next;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= udiv128_pkg::ST_IDLE;
            count_reg <= '0;
        end
        else
        begin
            state_reg <= state_next;
            count_reg <= count_next;
        end
    end

    always_comb
    begin
        state_next = state_reg;
        unique case (state_reg)
            udiv128_pkg::ST_IDLE:
            begin
                if (start)
                    state_next = udiv128_pkg::ST_RUN;
            end
            udiv128_pkg::ST_RUN:
            begin
                // A zero divisor needs no iterations; its result is fixed.
                if (status.divisor_zero || count_reg == udiv128_pkg::LastStep)
                    state_next = udiv128_pkg::ST_DONE;
            end
            udiv128_pkg::ST_DONE:
            begin
                if (start)
                    state_next = udiv128_pkg::ST_RUN;
                else
                    state_next = udiv128_pkg::ST_IDLE;
            end
            default:
                state_next = udiv128_pkg::ST_IDLE;
        endcase
    end

    always_comb
    begin
        cmd.load   = 1'b0;
        cmd.step   = 1'b0;
        busy       = 1'b0;
        done       = 1'b0;
        count_next = count_reg;
        unique case (state_reg)
            udiv128_pkg::ST_IDLE:
            begin
                cmd.load = start;
                if (start)
                    count_next = '0;
            end
            udiv128_pkg::ST_RUN:
            begin
                busy       = 1'b1;
                cmd.step   = !status.divisor_zero;
                count_next = count_reg + 1'b1;
            end
            udiv128_pkg::ST_DONE:
            begin
                // The result shows for this one cycle; a new transaction may load at its end.
                done     = 1'b1;
                cmd.load = start;
                if (start)
                    count_next = '0;
            end
            default:
            begin
                busy = 1'b0;
            end
        endcase
    end

endmodule

### design/udiv128_dp.sv
// Datapath of the divider: partial remainder, dividend/quotient shift register, divisor.
module udiv128_dp (
    input  logic                         clk,
    input  udiv128_pkg::udiv128_in_t      operands,
    input  udiv128_pkg::udiv128_cmd_t     cmd,
    output udiv128_pkg::udiv128_status_t  status,
    output udiv128_pkg::udiv128_out_t     result
);

    localparam int unsigned W = udiv128_pkg::WordWidth;

    logic [W-1:0]   rem_reg, rem_next;
    logic [2*W-1:0] shift_reg, shift_next;
    logic [W-1:0]   den_reg, den_next;
    logic           dz_reg, dz_next;

    logic [W:0] trial;
    logic [W:0] diff;
    logic       fits;

    always_ff @(posedge clk)
    begin
        rem_reg   <= rem_next;
        shift_reg <= shift_next;
        den_reg   <= den_next;
        dz_reg    <= dz_next;
    end

    // The remainder is 65 bits wide after the shift, so the top bit takes part in the compare.
    assign trial = {rem_reg, shift_reg[2*W-1]};
    assign diff  = trial - {1'b0, den_reg};
    assign fits  = trial >= {1'b0, den_reg};

    always_comb
    begin
        rem_next   = rem_reg;
        shift_next = shift_reg;
        den_next   = den_reg;
        dz_next    = dz_reg;
        if (cmd.load)
        begin
            rem_next   = '0;
            shift_next = {operands.dividend_high, operands.dividend_low};
            den_next   = operands.divisor;
            dz_next    = (operands.divisor == '0);
        end
        else if (cmd.step)
        begin
            // Dividend bits leave at the top while quotient bits enter at the bottom.
            rem_next   = fits ? diff[W-1:0] : trial[W-1:0];
            shift_next = {shift_reg[2*W-2:0], fits};
        end
    end

    assign status.divisor_zero = dz_reg;

    always_comb
    begin
        result.divide_by_zero = dz_reg;
        if (dz_reg)
        begin
            result.quotient_high = '1;
            result.quotient_low  = '1;
        end
        else
        begin
            result.quotient_high = shift_reg[2*W-1:W];
            result.quotient_low  = shift_reg[W-1:0];
        end
    end

endmodule

### design/unsigned_divide_128_by_64_unit.sv
// Top level of the unsigned 128-by-64 restoring divider.
//
// Usage: drive operands (dividend halves and divisor) and raise start while
// busy is low; the transaction is taken at that clock edge. busy then stays
// high while the divider iterates, one quotient bit per cycle, each from the
// single shared 65-bit compare-and-subtract step.
// The cycle after the last step, done is high for exactly one cycle and
// result carries the 128-bit quotient and the divide-by-zero flag. The
// receiver cannot stall, so the result must be captured in that cycle.
// busy is low while done is shown, so a new transaction may start then.
// A zero divisor skips the iterations and returns an all-ones quotient
// with the flag set. The divider takes no new transaction until the one
// in progress has finished.
// Reset (rst_n low, asynchronous) returns the sequencer to idle and drops
// any transaction in progress; the datapath registers are not reset.
module unsigned_divide_128_by_64_unit (
    input  logic                      clk,
    input  logic                      rst_n,
    input  logic                      start,
    input  udiv128_pkg::udiv128_in_t  operands,
    output logic                      busy,
    output logic                      done,
    output udiv128_pkg::udiv128_out_t result
);

    udiv128_pkg::udiv128_cmd_t    cmd;
    udiv128_pkg::udiv128_status_t status;

    udiv128_ctrl u_ctrl (
        .clk    (clk),
        .rst_n  (rst_n),
        .start  (start),
        .status (status),
        .cmd    (cmd),
        .busy   (busy),
        .done   (done)
    );

    udiv128_dp u_dp (
        .clk      (clk),
        .operands (operands),
        .cmd      (cmd),
        .status   (status),
        .result   (result)
    );

endmodule

### design/udiv128_chk.sv
// Port-level checker for the divider, bound to the top level.
module udiv128_chk (
    input logic                      clk,
    input logic                      rst_n,
    input logic                      start,
    input logic                      busy,
    input logic                      done,
    input udiv128_pkg::udiv128_out_t result
);

    a_done_not_busy: assert property (@(posedge clk) disable iff (!rst_n)
        done |-> !busy)
        else $error("done shown while busy");

    a_accept_busy: assert property (@(posedge clk) disable iff (!rst_n)
        (start && !busy) |=> busy)
        else $error("accepted transaction did not raise busy");

    a_busy_end_done: assert property (@(posedge clk) disable iff (!rst_n)
        ($past(busy) && !busy) |-> done)
        else $error("busy dropped without a result");

    a_done_single: assert property (@(posedge clk) disable iff (!rst_n)
        done |=> !done)
        else $error("result strobe lasted more than one cycle");

    a_zero_all_ones: assert property (@(posedge clk) disable iff (!rst_n)
        (done && result.divide_by_zero) |->
            (result.quotient_high == '1 && result.quotient_low == '1))
        else $error("divide by zero without all-ones quotient");

endmodule

bind unsigned_divide_128_by_64_unit udiv128_chk u_udiv128_chk (
    .clk    (clk),
    .rst_n  (rst_n),
    .start  (start),
    .busy   (busy),
    .done   (done),
    .result (result)
);
